### sv/ppm_rd_pkg.sv
// Shared types and constants of the binary PPM raster decoder.
package ppm_rd_pkg;

    localparam int unsigned DIM_BITS  = 12;
    localparam int unsigned DIM_LIM   = 32'd1 << DIM_BITS;
    localparam int unsigned DIM_W     = DIM_BITS + 1;
    localparam int unsigned FP_W      = 2 * DIM_BITS + 1;
    localparam int unsigned PIX_W     = 2 * DIM_BITS;

    localparam int unsigned MAX_W     = 16;
    localparam int unsigned SIZE_W    = 13;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned FRAC_W    = 17;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [MAX_W-1:0] ONE_BYTE_MAX = 16'd255;

    localparam int unsigned DIV_STEPS = 16;
    localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [MAX_W-1:0]   MAX_RESET  = 16'd255;
    localparam logic [SIZE_W-1:0]  SIZE_RESET = 13'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_VALUE    = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_SAMPLE    = 2'd0,
        ST_BAD_SEP   = 2'd1,
        ST_ABOVE_MAX = 2'd2,
        ST_TRUNC     = 2'd3
    } t_status;

    localparam logic [1:0] CH_RED  = 2'd0;
    localparam logic [1:0] CH_BLUE = 2'd2;

    typedef struct packed {
        logic    restart;
        logic    load_high;
        logic    use_high;
        logic    take_sample;
        logic    capture_err;
        t_status err_code;
        logic    div_step;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic is_ws;
        logic wide_max;
        logic above_max;
        logic frame_empty;
        logic is_last;
        logic div_last;
        logic out_free;
    } t_stat;

    function automatic logic [DIM_W-1:0] sat_dim(input logic [SIZE_W-1:0] v);
        if (32'(v) > DIM_LIM) begin
            return DIM_W'(DIM_LIM);
        end
        return DIM_W'(v);
    endfunction

endpackage

### sv/ppm_rd_ctrl.sv
// Controller: handshake sequencing and raster parse phase.
module ppm_rd_ctrl
    import ppm_rd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_OUT  = 3'b100
    } t_state;

    typedef enum logic [3:0] {
        P_SEP   = 4'b0001,
        P_FIRST = 4'b0010,
        P_LOW   = 4'b0100,
        P_HALT  = 4'b1000
    } t_phase;

    t_state r_state, n_state;
    t_phase r_phase, n_phase;
    logic   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_phase <= P_SEP;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = (r_state == S_IDLE) && i_in_valid;

    always_comb begin
        o_cmd          = '0;
        o_cmd.err_code = ST_SAMPLE;
        o_cmd.use_high = (r_phase == P_LOW);
        n_state        = r_state;
        n_phase        = r_phase;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_stat.kind) begin
                        o_cmd.restart = 1'b1;
                        n_phase       = P_SEP;
                        if (r_phase == P_SEP) begin
                            o_cmd.capture_err = 1'b1;
                            o_cmd.err_code    = ST_BAD_SEP;
                            n_state           = S_OUT;
                        end else if (r_phase == P_FIRST || r_phase == P_LOW) begin
                            o_cmd.capture_err = 1'b1;
                            o_cmd.err_code    = ST_TRUNC;
                            n_state           = S_OUT;
                        end
                    end else if (r_phase == P_SEP) begin
                        if (i_stat.is_ws) begin
                            n_phase = i_stat.frame_empty ? P_HALT : P_FIRST;
                        end else begin
                            o_cmd.capture_err = 1'b1;
                            o_cmd.err_code    = ST_BAD_SEP;
                            n_phase           = P_HALT;
                            n_state           = S_OUT;
                        end
                    end else if (r_phase == P_FIRST && i_stat.wide_max) begin
                        o_cmd.load_high = 1'b1;
                        n_phase         = P_LOW;
                    end else if (r_phase == P_FIRST || r_phase == P_LOW) begin
                        if (i_stat.above_max) begin
                            o_cmd.capture_err = 1'b1;
                            o_cmd.err_code    = ST_ABOVE_MAX;
                            n_phase           = P_HALT;
                            n_state           = S_OUT;
                        end else begin
                            o_cmd.take_sample = 1'b1;
                            n_phase           = i_stat.is_last ? P_HALT : P_FIRST;
                            n_state           = S_DIV;
                        end
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/ppm_rd_dp.sv
// Datapath: configuration, sample assembly, counters, divider and output register.
module ppm_rd_dp
    import ppm_rd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [MAX_W-1:0]      i_cfg_data,
    input  logic                  i_kind,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic                  i_out_stall,
    output logic                  o_out_valid,
    output logic [1:0]            o_status,
    output logic [1:0]            o_channel,
    output logic [MAX_W-1:0]      o_raw_sample,
    output logic [FRAC_W-1:0]     o_fraction,
    output logic                  o_frame_last,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat
);

    logic [MAX_W-1:0]     r_max;
    logic [SIZE_W-1:0]    r_width;
    logic [SIZE_W-1:0]    r_height;

    logic [BYTE_W-1:0]    r_high;
    logic [1:0]           r_chan;
    logic [PIX_W-1:0]     r_pix;

    t_status              r_res_status;
    logic [1:0]           r_res_channel;
    logic [MAX_W-1:0]     r_res_raw;
    logic                 r_res_last;

    logic [MAX_W-1:0]     r_div_d;
    logic [MAX_W-1:0]     r_rem;
    logic [FRAC_W-1:0]    r_quot;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    logic                 r_out_valid;
    logic [1:0]           r_out_status;
    logic [1:0]           r_out_channel;
    logic [MAX_W-1:0]     r_out_raw;
    logic [FRAC_W-1:0]    r_out_frac;
    logic                 r_out_last;

    logic [FP_W-1:0]      frame_pixels;
    logic [MAX_W-1:0]     raw;
    logic                 is_last;
    logic [MAX_W-1:0]     div_d;
    logic                 q_top;
    logic [MAX_W:0]       trial;
    logic                 trial_ge;

    assign frame_pixels = FP_W'(sat_dim(r_width)) * FP_W'(sat_dim(r_height));
    assign raw = i_cmd.use_high ? {r_high, i_data_byte} : MAX_W'(i_data_byte);
    assign is_last = (r_chan >= CH_BLUE) && ((FP_W'(r_pix) + FP_W'(1)) >= frame_pixels);

    assign o_stat.kind        = i_kind;
    assign o_stat.is_ws       = ((i_data_byte >= 8'd9) && (i_data_byte <= 8'd13))
                                || (i_data_byte == 8'd32);
    assign o_stat.wide_max    = (r_max > ONE_BYTE_MAX);
    assign o_stat.above_max   = (raw > r_max);
    assign o_stat.frame_empty = (frame_pixels == '0);
    assign o_stat.is_last     = is_last;
    assign o_stat.div_last    = (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    assign o_stat.out_free    = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= MAX_RESET;
            r_width  <= SIZE_RESET;
            r_height <= SIZE_RESET;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_VALUE:    r_max    <= i_cfg_data;
                    CFG_IMAGE_WIDTH:  r_width  <= i_cfg_data[SIZE_W-1:0];
                    CFG_IMAGE_HEIGHT: r_height <= i_cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= '0;
            r_chan <= CH_RED;
            r_pix  <= '0;
        end else if (i_cmd.restart) begin
            r_high <= '0;
            r_chan <= CH_RED;
            r_pix  <= '0;
        end else begin
            if (i_cmd.load_high) begin
                r_high <= i_data_byte;
            end
            if (i_cmd.take_sample) begin
                if (r_chan >= CH_BLUE) begin
                    r_chan <= CH_RED;
                    r_pix  <= r_pix + PIX_W'(1);
                end else begin
                    r_chan <= r_chan + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_res_status  <= ST_SAMPLE;
            r_res_channel <= r_chan;
            r_res_raw     <= raw;
            r_res_last    <= is_last;
        end else if (i_cmd.capture_err) begin
            r_res_status  <= i_cmd.err_code;
            r_res_channel <= r_chan;
            r_res_raw     <= (i_cmd.err_code == ST_ABOVE_MAX) ? raw : '0;
            r_res_last    <= 1'b0;
        end
    end

    assign div_d    = (r_max == '0) ? MAX_W'(1) : r_max;
    assign q_top    = (raw == div_d);
    assign trial    = {r_rem, 1'b0};
    assign trial_ge = (trial >= {1'b0, r_div_d});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (i_cmd.take_sample) begin
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take_sample) begin
            r_div_d <= div_d;
            r_rem   <= q_top ? '0 : raw;
            r_quot  <= {{(FRAC_W-1){1'b0}}, q_top};
        end else if (i_cmd.div_step) begin
            r_rem  <= trial_ge ? MAX_W'(trial - {1'b0, r_div_d}) : trial[MAX_W-1:0];
            r_quot <= {r_quot[FRAC_W-2:0], trial_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status  <= r_res_status;
            r_out_channel <= r_res_channel;
            r_out_raw     <= r_res_raw;
            r_out_frac    <= (r_res_status == ST_SAMPLE) ? r_quot : '0;
            r_out_last    <= r_res_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_status     = r_out_status;
    assign o_channel    = r_out_channel;
    assign o_raw_sample = r_out_raw;
    assign o_fraction   = r_out_frac;
    assign o_frame_last = r_out_last;

endmodule

### sv/ppm_binary_raster_decoder.sv
// Top level of the binary PPM raster decoder.
//
// Input channel: one transaction per raster byte (i_kind 0) or end marker
// (i_kind 1), taken when i_in_valid is high and o_in_stall is low.
// Output channel: one transaction per sample or error report, held in an
// output register until taken (o_out_valid high, i_out_stall low).
// Configuration: i_cfg_we writes max_value (0), image_width (1) or
// image_height (2) from i_cfg_data; write only while the block is idle.
// Sample path: a data byte that completes a sample is taken, the restoring
// divider then produces one quotient bit per step in state S_DIV, and the
// result is loaded into the output register from state S_OUT once that
// register is free.
// The input stalls while the divider runs and while a result waits for the
// output register; bytes and markers with no result do not stall it.
// The next byte is taken as soon as the result sits in the output register.
// Reset: synchronous, active low; returns the registers to max 255 and
// a 1 by 1 image, and the parser to awaiting its separator.
// Receiver stall: the output register holds its transaction; a further
// result waits in the datapath result registers and the input stalls until it moves on.
module ppm_binary_raster_decoder
    import ppm_rd_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MAX_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_kind,
    input  logic [BYTE_W-1:0]    i_data_byte,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [1:0]           o_channel,
    output logic [MAX_W-1:0]     o_raw_sample,
    output logic [FRAC_W-1:0]    o_fraction,
    output logic                 o_frame_last
);

    t_cmd  cmd;
    t_stat stat;

    ppm_rd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ppm_rd_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_data_byte  (i_data_byte),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_status     (o_status),
        .o_channel    (o_channel),
        .o_raw_sample (o_raw_sample),
        .o_fraction   (o_fraction),
        .o_frame_last (o_frame_last),
        .i_cmd        (cmd),
        .o_stat       (stat)
    );

endmodule

### dv/tb_top.sv
// Self-checking testbench of the binary PPM raster decoder: directed and random byte streams.
`timescale 1ns / 100ps

module tb_top;
    import ppm_rd_pkg::*;

    localparam logic       KIND_DATA    = 1'b0;
    localparam logic       KIND_END     = 1'b1;
    localparam logic [7:0] SEP_TAB      = 8'd9;
    localparam logic [7:0] SEP_CR       = 8'd13;
    localparam logic [7:0] SEP_SPACE    = 8'd32;
    localparam int unsigned IDLE_PCT     = 33;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned DRAIN_CYCLES = 24;
    localparam int unsigned QUIET_LIMIT  = 4000;
    localparam int unsigned ITEMS_TARGET = 1450;
    localparam int unsigned SAMPLE_CAP   = 36;

    typedef enum logic [1:0] {
        AWAIT_SEP    = 2'd0,
        AWAIT_SAMPLE = 2'd1,
        AWAIT_LOW    = 2'd2,
        HALTED       = 2'd3
    } t_parse;

    typedef struct packed {
        t_status           status;
        logic [1:0]        channel;
        logic [MAX_W-1:0]  raw;
        logic [FRAC_W-1:0] frac;
        logic              last;
    } t_sample_out;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [MAX_W-1:0]     i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic                 i_kind;
    logic [BYTE_W-1:0]    i_data_byte;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [1:0]           o_status;
    logic [1:0]           o_channel;
    logic [MAX_W-1:0]     o_raw_sample;
    logic [FRAC_W-1:0]    o_fraction;
    logic                 o_frame_last;

    logic [MAX_W-1:0]  m_max;
    logic [SIZE_W-1:0] m_width;
    logic [SIZE_W-1:0] m_height;
    t_parse            m_phase;
    logic [BYTE_W-1:0] m_high;
    logic [1:0]        m_chan;
    int unsigned       m_pixels;

    t_sample_out pending_samples[$];
    int unsigned mismatches   = 0;
    int unsigned items_sent   = 0;
    int unsigned quiet_cycles = 0;
    bit          calm         = 1'b0;
    bit          hold_request = 1'b0;

    ppm_binary_raster_decoder i_dut (.*);

    always #1 i_clk = ~i_clk;

    function automatic int unsigned frame_size();
        int unsigned w;
        int unsigned h;
        w = (m_width > DIM_LIM) ? DIM_LIM : m_width;
        h = (m_height > DIM_LIM) ? DIM_LIM : m_height;
        return w * h;
    endfunction

    function automatic void restart_parser();
        m_phase  = AWAIT_SEP;
        m_high   = '0;
        m_chan   = CH_RED;
        m_pixels = 0;
    endfunction

    function automatic void push_result(t_status st, logic [MAX_W-1:0] raw,
                                        logic [FRAC_W-1:0] frac, logic last);
        t_sample_out r;
        r.status  = st;
        r.channel = m_chan;
        r.raw     = raw;
        r.frac    = frac;
        r.last    = last;
        pending_samples.push_back(r);
    endfunction

    function automatic void take_sample(logic [MAX_W-1:0] raw);
        logic [32:0]       num;
        logic [16:0]       div;
        logic              last;
        if (raw > m_max) begin
            push_result(ST_ABOVE_MAX, raw, '0, 1'b0);
            m_phase = HALTED;
            return;
        end
        num  = {raw, 16'h0000};
        div  = (m_max == '0) ? 17'd1 : {1'b0, m_max};
        last = (m_chan >= CH_BLUE) && (m_pixels + 1 >= frame_size());
        push_result(ST_SAMPLE, raw, FRAC_W'(num / div), last);
        if (m_chan >= CH_BLUE) begin
            m_chan = CH_RED;
            m_pixels++;
        end else begin
            m_chan++;
        end
        m_phase = last ? HALTED : AWAIT_SAMPLE;
    endfunction

    function automatic void decode_byte(logic kind, logic [BYTE_W-1:0] b);
        if (kind == KIND_END) begin
            if (m_phase == AWAIT_SEP) begin
                push_result(ST_BAD_SEP, '0, '0, 1'b0);
            end else if (m_phase != HALTED) begin
                push_result(ST_TRUNC, '0, '0, 1'b0);
            end
            restart_parser();
            return;
        end
        case (m_phase)
            AWAIT_SEP: begin
                if ((b >= SEP_TAB && b <= SEP_CR) || b == SEP_SPACE) begin
                    m_phase = (frame_size() == 0) ? HALTED : AWAIT_SAMPLE;
                end else begin
                    push_result(ST_BAD_SEP, '0, '0, 1'b0);
                    m_phase = HALTED;
                end
            end
            AWAIT_SAMPLE: begin
                if (m_max > ONE_BYTE_MAX) begin
                    m_high  = b;
                    m_phase = AWAIT_LOW;
                end else begin
                    take_sample({8'h00, b});
                end
            end
            AWAIT_LOW: take_sample({m_high, b});
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function automatic logic [BYTE_W-1:0] pick_separator();
        int unsigned k;
        k = $urandom_range(5);
        return (k == 5) ? SEP_SPACE : SEP_TAB + BYTE_W'(k);
    endfunction

    function automatic logic [SIZE_W-1:0] pick_dim();
        int unsigned k;
        k = $urandom_range(19);
        if (k == 0) return '0;
        if (k <= 2) return SIZE_W'($urandom_range(4095, 8191));
        return SIZE_W'($urandom_range(1, 4));
    endfunction

    // Result checking
    always @(posedge i_clk) begin
        t_sample_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                $error("unexpected transaction: status %0d raw %0d", o_status, o_raw_sample);
                mismatches++;
            end else begin
                want = pending_samples.pop_front();
                check_field("status", want.status, o_status);
                check_field("channel", want.channel, o_channel);
                check_field("raw_sample", want.raw, o_raw_sample);
                check_field("fraction", want.frac, o_fraction);
                check_field("frame_last", want.last, o_frame_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("** ppm_binary_raster_decoder: FAILED **");
            $finish;
        end
    end

    // Receiver
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    task automatic send_item(logic kind, logic [BYTE_W-1:0] b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_kind      <= kind;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (m_phase != HALTED || kind == KIND_END) items_sent++;
        decode_byte(kind, b);
    endtask

    task automatic wait_results();
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [MAX_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_MAX_VALUE:    m_max    = value;
            CFG_IMAGE_WIDTH:  m_width  = value[SIZE_W-1:0];
            CFG_IMAGE_HEIGHT: m_height = value[SIZE_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_frame(logic [MAX_W-1:0] max_v, logic [SIZE_W-1:0] w,
                             logic [SIZE_W-1:0] h);
        wait_results();
        write_reg(CFG_MAX_VALUE, max_v);
        write_reg(CFG_IMAGE_WIDTH, MAX_W'(w));
        write_reg(CFG_IMAGE_HEIGHT, MAX_W'(h));
    endtask

    task automatic test_default_frame();
        send_item(KIND_DATA, SEP_SPACE);
        send_item(KIND_DATA, 8'd0);
        send_item(KIND_DATA, 8'd255);
        send_item(KIND_DATA, 8'd128);
        send_item(KIND_DATA, 8'd7);
        send_item(KIND_END, 8'hA5);
    endtask

    task automatic test_separators();
        send_item(KIND_END, 8'h00);
        send_item(KIND_DATA, 8'd8);
        send_item(KIND_END, 8'hFF);
        send_item(KIND_DATA, SEP_TAB);
        send_item(KIND_END, 8'h5A);
    endtask

    task automatic test_sample_limits();
        set_frame(16'hFFFF, 13'd8191, 13'd8191);
        send_item(KIND_DATA, SEP_CR);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'hFF);
        send_item(KIND_DATA, 8'h12);
        send_item(KIND_END, 8'h00);
        set_frame(16'd0, 13'd0, 13'd4096);
        send_item(KIND_DATA, SEP_SPACE);
        send_item(KIND_END, 8'h00);
        set_frame(16'd0, 13'd1, 13'd1);
        send_item(KIND_DATA, SEP_SPACE);
        send_item(KIND_DATA, 8'd0);
        send_item(KIND_DATA, 8'd1);
        send_item(KIND_END, 8'h00);
    endtask

    task automatic test_midstream_change();
        set_frame(16'd300, 13'd1, 13'd1);
        send_item(KIND_DATA, SEP_SPACE);
        send_item(KIND_DATA, 8'd1);
        wait_results();
        write_reg(CFG_MAX_VALUE, 16'd200);
        send_item(KIND_DATA, 8'd5);
        send_item(KIND_END, 8'h00);
    endtask

    task automatic test_backpressure();
        set_frame(ONE_BYTE_MAX, 13'd4, 13'd2);
        hold_request = 1'b1;
        send_item(KIND_DATA, SEP_SPACE);
        repeat (24) send_item(KIND_DATA, 8'($urandom));
        send_item(KIND_END, 8'($urandom));
        wait_results();
    endtask

    task automatic send_frame();
        int unsigned count;
        int unsigned cut_at;
        int unsigned lim;
        int unsigned top;
        int unsigned raw;
        send_item(KIND_DATA, ($urandom_range(9) == 0) ? 8'($urandom) : pick_separator());
        count  = 3 * frame_size();
        count  = (count > SAMPLE_CAP) ? SAMPLE_CAP : count;
        cut_at = ($urandom_range(9) == 0) ? $urandom_range(count) : count + 1;
        for (int unsigned i = 0; i < count && m_phase != HALTED; i++) begin
            if (i == cut_at) begin
                // shrink the frame to a single pixel while it is being read
                wait_results();
                write_reg(CFG_IMAGE_WIDTH, 16'd1);
                write_reg(CFG_IMAGE_HEIGHT, 16'd1);
            end
            lim = m_max;
            top = (m_max > ONE_BYTE_MAX) ? 65535 : 255;
            case ($urandom_range(19))
                0:       raw = lim;
                1:       raw = 0;
                2:       raw = $urandom_range(lim, top);
                default: raw = $urandom_range(lim);
            endcase
            if (m_max > ONE_BYTE_MAX) begin
                send_item(KIND_DATA, raw[15:8]);
                if ($urandom_range(49) == 0) break;
            end
            send_item(KIND_DATA, raw[7:0]);
        end
        repeat ($urandom_range(2)) send_item(KIND_DATA, 8'($urandom));
        if ($urandom_range(9) != 0) send_item(KIND_END, 8'($urandom));
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8)) begin
            if ($urandom_range(4) == 0) begin
                send_item(KIND_END, 8'($urandom));
            end else begin
                send_item(KIND_DATA, ($urandom_range(2) == 0) ? pick_separator() : 8'($urandom));
            end
        end
        send_item(KIND_END, 8'($urandom));
    endtask

    task automatic test_random_frames();
        int unsigned frame_no;
        frame_no = 0;
        while (items_sent < ITEMS_TARGET) begin
            calm = (frame_no >= 12 && frame_no < 22);
            if ($urandom_range(99) < 40) begin
                case ($urandom_range(9))
                    0:       set_frame(16'd0, pick_dim(), pick_dim());
                    1:       set_frame(16'd1, pick_dim(), pick_dim());
                    2:       set_frame(ONE_BYTE_MAX, pick_dim(), pick_dim());
                    3:       set_frame(ONE_BYTE_MAX + 16'd1, pick_dim(), pick_dim());
                    4:       set_frame(16'hFFFF, pick_dim(), pick_dim());
                    5, 6:    set_frame(16'($urandom_range(2, 254)), pick_dim(), pick_dim());
                    default: set_frame(16'($urandom_range(257, 65534)), pick_dim(), pick_dim());
                endcase
            end
            if ($urandom_range(99) < 80) begin
                send_frame();
            end else begin
                send_noise();
            end
            frame_no++;
        end
        calm = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_MAX_VALUE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_kind      = KIND_DATA;
        i_data_byte = '0;
        m_max       = MAX_RESET;
        m_width     = SIZE_RESET;
        m_height    = SIZE_RESET;
        restart_parser();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_frame();
        test_separators();
        test_sample_limits();
        test_midstream_change();
        test_backpressure();
        test_random_frames();
        wait_results();

        if (mismatches == 0 && pending_samples.size() == 0) begin
            $display("** ppm_binary_raster_decoder: PASSED **");
        end else begin
            $display("** ppm_binary_raster_decoder: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
sv/ppm_rd_pkg.sv
sv/ppm_rd_ctrl.sv
sv/ppm_rd_dp.sv
sv/ppm_binary_raster_decoder.sv
dv/tb_top.sv
